// File: design/multi_stack_shared_pool_assert.svh
// ----------------------------------------------------------------------------
// multi_stack_shared_pool assertion macros
// implication checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_POOL_ASSERT_SVH
`define MULTI_STACK_SHARED_POOL_ASSERT_SVH

`ifndef SYNTHESIS
`define MSSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MSSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MSSP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSSP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/mssp_pkg.sv
// ----------------------------------------------------------------------------
// mssp_pkg
// types and constants for the shared pool stacks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mssp_pkg;

	localparam int NUM_STACKS = 4;
	localparam int POOL_SIZE  = 256;
	localparam int STACK_W    = 2;
	localparam int ADDR_W     = $clog2(POOL_SIZE);
	localparam int LINK_W     = ADDR_W + 1;
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SIZE);

	typedef logic [LINK_W-1:0] link_t;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		func_t               func;
		logic [STACK_W-1:0]  stack_id;
		logic signed [31:0]  value;
	} in_t;

	typedef struct packed {
		status_t             status;
		logic signed [31:0]  popped;
	} out_t;

endpackage

// File: design/multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// several lifo stacks sharing one pool of slots chained by a free list
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid / in_ready / in_data) carries one push or pop
//   transaction; out channel (out_valid / out_ready / out_data) returns one
//   status transaction for each, in order.
//   An accepted transaction reads the link and value memories in the cycle
//   of acceptance; once the result register is free to take it, the list
//   update stage changes the lists and loads the result register, which
//   raises out_valid. A new transaction is accepted only once the last one
//   has left the first stage, since its link read must be written back.
//   Reset empties every stack and puts all slots on the free list in order;
//   untouched slots are tracked by a fill count, so no clearing pass runs.
//   When the receiver stalls, one transaction may wait in the result
//   register and one more may be accepted and held in the first stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_stack_shared_pool_assert.svh"

module multi_stack_shared_pool (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mssp_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output mssp_pkg::out_t   out_data
);

	mssp_pkg::link_t stack_top_q [mssp_pkg::NUM_STACKS];
	mssp_pkg::link_t free_head_q;
	mssp_pkg::link_t fill_q;

	logic [31:0]            value_mem [mssp_pkg::POOL_SIZE];
	mssp_pkg::link_t        link_mem  [mssp_pkg::POOL_SIZE];
	logic [31:0]            value_rd_q;
	mssp_pkg::link_t        link_rd_q;

	logic                   busy_s1;
	mssp_pkg::in_t          item_s1;
	logic                   out_valid_q;
	mssp_pkg::out_t         out_data_q;

	logic                   accept;
	logic                   advance;
	logic [mssp_pkg::ADDR_W-1:0] rd_addr;

	logic                   sid_ok;
	logic                   is_pop;
	mssp_pkg::link_t        top_sel;
	mssp_pkg::link_t        slot;
	mssp_pkg::link_t        next_link;
	logic                   slot_null;
	logic                   do_push;
	logic                   do_pop;
	mssp_pkg::out_t         result;

	assign in_ready  = !busy_s1;
	assign accept    = in_valid && in_ready;
	assign advance   = busy_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		if (in_data.func == mssp_pkg::FUNC_POP) begin
			rd_addr = stack_top_q[in_data.stack_id][mssp_pkg::ADDR_W-1:0];
		end else begin
			rd_addr = free_head_q[mssp_pkg::ADDR_W-1:0];
		end
	end

	// list update stage, fed by the registered link read
	always_comb begin
		sid_ok    = 32'(item_s1.stack_id) < 32'(mssp_pkg::NUM_STACKS);
		is_pop    = item_s1.func == mssp_pkg::FUNC_POP;
		top_sel   = stack_top_q[item_s1.stack_id];
		slot      = is_pop ? top_sel : free_head_q;
		slot_null = slot == mssp_pkg::LINK_NULL;
		next_link = (slot >= fill_q) ? slot + mssp_pkg::LINK_W'(1) : link_rd_q;
		do_push   = advance && sid_ok && !is_pop && !slot_null;
		do_pop    = advance && sid_ok && is_pop && !slot_null;
		result.popped = '0;
		if (!sid_ok || slot_null) begin
			result.status = is_pop ? mssp_pkg::ST_EMPTY : mssp_pkg::ST_FULL;
		end else begin
			result.status = mssp_pkg::ST_DONE;
			if (is_pop) begin
				result.popped = value_rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			link_rd_q  <= link_mem[rd_addr];
			value_rd_q <= value_mem[rd_addr];
		end
		if (do_push) begin
			value_mem[slot[mssp_pkg::ADDR_W-1:0]] <= item_s1.value;
			link_mem[slot[mssp_pkg::ADDR_W-1:0]]  <= top_sel;
		end else if (do_pop) begin
			link_mem[slot[mssp_pkg::ADDR_W-1:0]]  <= free_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			free_head_q <= '0;
			fill_q      <= '0;
			for (int i = 0; i < mssp_pkg::NUM_STACKS; i++) begin
				stack_top_q[i] <= mssp_pkg::LINK_NULL;
			end
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (advance) begin
				busy_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_push) begin
				free_head_q                   <= next_link;
				stack_top_q[item_s1.stack_id] <= slot;
				if (slot == fill_q) begin
					fill_q <= fill_q + mssp_pkg::LINK_W'(1);
				end
			end else if (do_pop) begin
				stack_top_q[item_s1.stack_id] <= next_link;
				free_head_q                   <= slot;
			end
		end
	end

	`MSSP_ASSERT_NXT(a_one_in_flight, clk, arst_n, accept, !in_ready)
	`MSSP_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= mssp_pkg::LINK_NULL)
	`MSSP_ASSERT_IMP(a_result_source, clk, arst_n, $rose(out_valid), $past(busy_s1))
	`MSSP_ASSERT_IMP(a_pop_not_fresh, clk, arst_n, do_pop, slot < fill_q)

endmodule
